/* src/lpr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the LRU page replacement core.
// No dependencies; the files that use it refer to this package by scoped names.
package lpr_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 8;
  localparam int CFG_W          = 4;   // frames_in_use register width
  localparam int FIDX_OUT_W     = 3;   // frame_index field width
  localparam int FAULT_W        = 32;  // fault_count field width

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT_RD,
    ST_EVICT,
    ST_DONE
  } lpr_state_t;

  // Commands from the controller to the recency stack.
  typedef struct packed {
    logic clear;  // restore the reset order
    logic touch;  // move a frame to the most recent end
  } rec_cmd_t;

endpackage

/* src/lpr_frame_ram.sv */
`timescale 1ns / 1ps
// Page-number store for the frames: one write port, one read port,
// registered read data. Uses no package items.
module lpr_frame_ram #(
  parameter int DEPTH  = 8,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/lpr_recency.sv */
`timescale 1ns / 1ps
// Recency stack of frame indices: position 0 least recent, top most recent.
// Depends on lpr_pkg for the command struct.
module lpr_recency #(
  parameter int MAX_FRAMES = 8,
  parameter int ADDR_W     = 3,
  parameter int CNT_W      = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  lpr_pkg::rec_cmd_t cmd,
  input  logic [ADDR_W-1:0] touch_frame,
  input  logic [CNT_W-1:0]  frames_used,
  output logic [ADDR_W-1:0] lru_frame
);

  logic [ADDR_W-1:0] order      [MAX_FRAMES];
  logic [ADDR_W-1:0] order_next [MAX_FRAMES];

  // Shift everything above the touched frame down one place.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      seen = seen | (order[i] == touch_frame);
      if (i == MAX_FRAMES - 1) begin
        order_next[i] = touch_frame;
      end else if (seen) begin
        order_next[i] = order[(i + 1) % MAX_FRAMES];
      end else begin
        order_next[i] = order[i];
      end
    end
  end

  // Least recent frame among those in use.
  always_comb begin
    lru_frame = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (CNT_W'(order[i]) < frames_used) begin
        lru_frame = order[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        order[i] <= ADDR_W'(i);
      end
    end else if (cmd.touch) begin
      order <= order_next;
    end
  end

endmodule

/* src/lru_page_replacement_core.sv */
`timescale 1ns / 1ps
// Top level of the LRU page replacement core: control, valid bits, fault count.
// Depends on lpr_pkg, lpr_frame_ram and lpr_recency.
//
// One word in on the slave stream carries a page reference (page in tdata,
// first_ref in tuser); one word out on the master stream reports the outcome.
// The core holds MAX_FRAMES fully associative frames whose page numbers live
// in a single-read-port RAM, so a lookup walks the frames in use one per
// cycle, stopping at the first match. A hit in frame 0 is the quickest item;
// a fault that evicts the least recently used page is the slowest, as it
// needs a second read of the RAM, and the scan through the one read port
// sets the pace. A finished word waits in the output register, so the next
// reference is taken while it is still held. first_ref clears the valid
// bits, the recency order and the fault count in the accept cycle.
// frames_in_use is written through cfg_we / cfg_data; the user must write it
// only while idle, which the core itself does not enforce. 0 reads as 1 and
// values above MAX_FRAMES as MAX_FRAMES. fault_count saturates at all ones.
module lru_page_replacement_core #(
  parameter int MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration: frames_in_use
  input  logic                   cfg_we,
  input  logic [lpr_pkg::CFG_W-1:0] cfg_data,
  // slave stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [((PAGE_BITS+7)/8)*8-1:0] s_tdata,  // [PAGE_BITS-1:0] page
  input  logic                   s_tuser,          // [0] first_ref
  // master stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // from bit 0: frame_index (3), evicted_valid (1), evicted_page (PAGE_BITS),
  // fault_count (32), zero fill
  output logic [((lpr_pkg::FIDX_OUT_W+1+PAGE_BITS+lpr_pkg::FAULT_W+7)/8)*8-1:0] m_tdata,
  output logic                   m_tuser           // [0] fault
);

  localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W  = (CNT_W > lpr_pkg::CFG_W) ? CNT_W : lpr_pkg::CFG_W;
  localparam int OUT_W  =
    ((lpr_pkg::FIDX_OUT_W + 1 + PAGE_BITS + lpr_pkg::FAULT_W + 7) / 8) * 8;
  localparam logic [lpr_pkg::FAULT_W-1:0] FAULT_MAX = '1;

  lpr_pkg::lpr_state_t state, state_next;

  // configuration, held already clamped to 1..MAX_FRAMES
  logic [CNT_W-1:0] frames_used;

  // per-item working registers
  logic [PAGE_BITS-1:0] page_q;
  logic [CNT_W-1:0]     scan_addr;
  logic                 cmp_valid;
  logic [ADDR_W-1:0]    cmp_idx;
  logic [ADDR_W-1:0]    frame_sel;
  logic                 fault_q;
  logic                 ev_valid_q;
  logic [PAGE_BITS-1:0] ev_page_q;

  logic [MAX_FRAMES-1:0]      frame_valid;
  logic [lpr_pkg::FAULT_W-1:0] fault_total;
  logic [lpr_pkg::FAULT_W-1:0] fault_next;

  // output register
  logic                        m_fault;
  logic [lpr_pkg::FIDX_OUT_W-1:0] m_frame;
  logic                        m_ev_valid;
  logic [PAGE_BITS-1:0]        m_ev_page;
  logic [lpr_pkg::FAULT_W-1:0] m_count;

  // RAM port signals
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [PAGE_BITS-1:0] ram_rdata;

  // decode
  logic              in_accept;
  logic              out_free;
  logic              hit;
  logic              last_cmp;
  logic              scan_miss;
  logic              empty_found;
  logic [ADDR_W-1:0] free_idx;
  logic [ADDR_W-1:0] lru_frame;
  lpr_pkg::rec_cmd_t rec_cmd;

  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // A frame matches only behind its valid bit; stale RAM contents never count.
  assign hit = cmp_valid && frame_valid[cmp_idx] && (ram_rdata == page_q);
  assign last_cmp  = (CNT_W'(cmp_idx) + CNT_W'(1)) == frames_used;
  assign scan_miss = (state == lpr_pkg::ST_SCAN) && cmp_valid && !hit && last_cmp;

  // Lowest-numbered empty frame among those in use.
  always_comb begin
    empty_found = 1'b0;
    free_idx    = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (!frame_valid[i] && (CNT_W'(i) < frames_used)) begin
        empty_found = 1'b1;
        free_idx    = ADDR_W'(i);
      end
    end
  end

  assign fault_next = (fault_q && (fault_total != FAULT_MAX)) ?
                      fault_total + lpr_pkg::FAULT_W'(1) : fault_total;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lpr_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = lpr_pkg::ST_SCAN;
        end
      end
      lpr_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = lpr_pkg::ST_DONE;
        end else if (scan_miss) begin
          state_next = empty_found ? lpr_pkg::ST_DONE : lpr_pkg::ST_EVICT_RD;
        end
      end
      lpr_pkg::ST_EVICT_RD: state_next = lpr_pkg::ST_EVICT;
      lpr_pkg::ST_EVICT:    state_next = lpr_pkg::ST_DONE;
      lpr_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = lpr_pkg::ST_IDLE;
        end
      end
      default: state_next = lpr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_tready      = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = scan_addr[ADDR_W-1:0];
    ram_we        = 1'b0;
    ram_waddr     = free_idx;
    rec_cmd.clear = 1'b0;
    rec_cmd.touch = 1'b0;
    unique case (state)
      lpr_pkg::ST_IDLE: begin
        s_tready      = 1'b1;
        rec_cmd.clear = s_tvalid && s_tuser;
      end
      lpr_pkg::ST_SCAN: begin
        // issue one frame read per cycle until a match or until all frames in use are out
        ram_re = !hit && (scan_addr < frames_used);
        ram_we = scan_miss && empty_found;
      end
      lpr_pkg::ST_EVICT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = frame_sel;
      end
      lpr_pkg::ST_EVICT: begin
        ram_we    = 1'b1;
        ram_waddr = frame_sel;
      end
      lpr_pkg::ST_DONE: begin
        rec_cmd.touch = out_free;
      end
      default: begin
      end
    endcase
  end

  lpr_frame_ram #(
    .DEPTH  (MAX_FRAMES),
    .WIDTH  (PAGE_BITS),
    .ADDR_W (ADDR_W)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (page_q),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lpr_recency #(
    .MAX_FRAMES (MAX_FRAMES),
    .ADDR_W     (ADDR_W),
    .CNT_W      (CNT_W)
  ) u_recency (
    .clk         (clk),
    .rst         (rst),
    .cmd         (rec_cmd),
    .touch_frame (frame_sel),
    .frames_used (frames_used),
    .lru_frame   (lru_frame)
  );

  // state and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lpr_pkg::ST_IDLE;
      frames_used <= CNT_W'(MAX_FRAMES);
      frame_valid <= '0;
      fault_total <= '0;
      cmp_valid   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;

      // clamp the frame count on the way in
      if (cfg_we) begin
        if (cfg_data == '0) begin
          frames_used <= CNT_W'(1);
        end else if (CMP_W'(cfg_data) > CMP_W'(MAX_FRAMES)) begin
          frames_used <= CNT_W'(MAX_FRAMES);
        end else begin
          frames_used <= CNT_W'(cfg_data);
        end
      end

      if (in_accept && s_tuser) begin
        frame_valid <= '0;
        fault_total <= '0;
      end else if (ram_we) begin
        frame_valid[ram_waddr] <= 1'b1;
      end

      if (state == lpr_pkg::ST_SCAN) begin
        cmp_valid <= ram_re;
      end else begin
        cmp_valid <= 1'b0;
      end

      if (state == lpr_pkg::ST_DONE && out_free) begin
        fault_total <= fault_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      page_q     <= s_tdata[PAGE_BITS-1:0];
      scan_addr  <= '0;
      fault_q    <= 1'b0;
      ev_valid_q <= 1'b0;
      ev_page_q  <= '0;
    end

    if (state == lpr_pkg::ST_SCAN) begin
      cmp_idx <= scan_addr[ADDR_W-1:0];
      if (ram_re) begin
        scan_addr <= scan_addr + CNT_W'(1);
      end
      if (hit) begin
        frame_sel <= cmp_idx;
      end else if (scan_miss) begin
        fault_q   <= 1'b1;
        frame_sel <= empty_found ? free_idx : lru_frame;
      end
    end

    // old page of the victim frame arrives in the cycle after its read
    if (state == lpr_pkg::ST_EVICT) begin
      ev_valid_q <= 1'b1;
      ev_page_q  <= ram_rdata;
    end

    if (state == lpr_pkg::ST_DONE && out_free) begin
      m_fault    <= fault_q;
      m_frame    <= lpr_pkg::FIDX_OUT_W'(frame_sel);
      m_ev_valid <= ev_valid_q;
      m_ev_page  <= ev_page_q;
      m_count    <= fault_next;
    end
  end

  assign m_tuser = m_fault;
  assign m_tdata = OUT_W'({m_count, m_ev_page, m_ev_valid, m_frame});

`ifndef SYNTHESIS
  // A reported eviction always comes with a fault.
  a_evict_is_fault: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_ev_valid || m_fault))
    else $error("eviction reported without a fault");

  // The frame being reported holds a valid page.
  a_done_frame_valid: assert property (@(posedge clk) disable iff (rst)
    (state == lpr_pkg::ST_DONE) |-> frame_valid[frame_sel])
    else $error("reported frame is not valid");

  // The fault count only drops on a first_ref.
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(in_accept && s_tuser) |=> (fault_total >= $past(fault_total)))
    else $error("fault count went down");

  // A victim read is always followed by its write-back.
  a_evict_seq: assert property (@(posedge clk) disable iff (rst)
    (state == lpr_pkg::ST_EVICT_RD) |=> (state == lpr_pkg::ST_EVICT && ram_we))
    else $error("eviction sequence broken");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lru_page_replacement_core: page references in,
// hit/fault outcomes out, checked against an LRU predictor kept in step here.
// Depends on lpr_pkg and the core RTL only.
module tb;

  localparam int NUM_FRAMES    = lpr_pkg::MAX_FRAMES_DEF;
  localparam int SETTLE_CYCLES = 20;      // longer than the longest item
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 300;

  // one reported outcome, most significant field first
  typedef struct packed {
    logic        fault;
    logic [2:0]  frame_index;
    logic        evicted_valid;
    logic [7:0]  evicted_page;
    logic [31:0] fault_count;
  } ref_outcome_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        cfg_we   = 1'b0;
  logic [3:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] page
  logic        s_tuser  = 1'b0; // [0] first_ref
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // [2:0] frame_index, [3] evicted_valid,
                                // [11:4] evicted_page, [43:12] fault_count
  logic        m_tuser;         // [0] fault

  // traffic shaping
  logic calm    = 1'b0;         // no idling on either side
  logic hold_rx = 1'b0;         // receiver held off

  // predicted state of the core
  logic [7:0]  frame_page  [NUM_FRAMES];
  logic        frame_valid [NUM_FRAMES];
  logic [2:0]  lru_order   [NUM_FRAMES];   // position 0 is least recent
  logic [31:0] fault_total;
  logic [3:0]  frames_cfg;

  ref_outcome_t expected_outcomes[$];
  ref_outcome_t want, got;
  int mismatches = 0;
  int cycles     = 0;

  lru_page_replacement_core uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_frames();
    for (int i = 0; i < NUM_FRAMES; i++) begin
      frame_page[i]  = '0;
      frame_valid[i] = 1'b0;
      lru_order[i]   = 3'(i);
    end
    fault_total = '0;
  endfunction

  // Look up one page reference, update the frames and return the outcome.
  function automatic ref_outcome_t lookup_page(logic [7:0] pg, logic first_ref);
    ref_outcome_t o;
    int n;
    int slot;
    int pos;
    bit hit;
    bit found;
    o = '0;
    if (first_ref) clear_frames();
    n = frames_cfg;
    if (n == 0) n = 1;
    if (n > NUM_FRAMES) n = NUM_FRAMES;
    hit  = 1'b0;
    slot = 0;
    // lowest-numbered matching frame wins when a page sits in two frames
    for (int i = 0; i < n; i++)
      if (!hit && frame_valid[i] && frame_page[i] == pg) begin
        hit  = 1'b1;
        slot = i;
      end
    if (!hit) begin
      found = 1'b0;
      for (int i = 0; i < n; i++)
        if (!found && !frame_valid[i]) begin
          found = 1'b1;
          slot  = i;
        end
      if (!found) begin
        // least recent frame that is still in use
        for (int i = 0; i < NUM_FRAMES; i++)
          if (!found && lru_order[i] < n) begin
            found = 1'b1;
            slot  = lru_order[i];
          end
        o.evicted_valid = 1'b1;
        o.evicted_page  = frame_page[slot];
      end
      frame_page[slot]  = pg;
      frame_valid[slot] = 1'b1;
      if (fault_total != '1) fault_total++;
    end
    // move the frame to the most recent end
    pos = 0;
    while (pos < NUM_FRAMES && lru_order[pos] != 3'(slot)) pos++;
    for (int i = pos; i + 1 < NUM_FRAMES; i++) lru_order[i] = lru_order[i + 1];
    lru_order[NUM_FRAMES - 1] = 3'(slot);
    o.fault       = !hit;
    o.frame_index = 3'(slot);
    o.fault_count = fault_total;
    return o;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one reference word, with random idle cycles ahead of it unless calm.
  task automatic send_ref(input logic [7:0] pg, input logic first_ref);
    while (!calm && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pg;
    s_tuser  <= first_ref;
    do @(posedge clk); while (!s_tready);
    expected_outcomes.push_back(lookup_page(pg, first_ref));
  endtask

  // Drop valid, wait for every outcome, then let the core go quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frames(input logic [3:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    frames_cfg = value;
  endtask

  // Receiver: random stalls unless calm, never ready while held off.
  always @(posedge clk)
    m_tready <= !hold_rx && (calm || $urandom_range(99) >= 29);

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[2:0], m_tdata[3], m_tdata[11:4], m_tdata[43:12]};
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected outcome word: fault=%0d frame=%0d ev=%0d/%0d count=%0d",
                   got.fault, got.frame_index, got.evicted_valid, got.evicted_page,
                   got.fault_count);
      end else begin
        want = expected_outcomes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"outcome mismatch: expected fault=%0d frame=%0d ev=%0d/%0d ",
                      "count=%0d, got fault=%0d frame=%0d ev=%0d/%0d count=%0d"},
                     want.fault, want.frame_index, want.evicted_valid,
                     want.evicted_page, want.fault_count, got.fault,
                     got.frame_index, got.evicted_valid, got.evicted_page,
                     got.fault_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // Default frame count: fill all frames, hit, then evict the least recent.
  task automatic test_default_fill();
    send_ref(8'd0, 1'b1);
    send_ref(8'd255, 1'b0);
    for (int p = 1; p <= 6; p++) send_ref(8'(p), 1'b0);
    send_ref(8'd0, 1'b0);     // hit in frame 0
    send_ref(8'd200, 1'b0);   // evicts page 255
    send_ref(8'd255, 1'b0);   // back in, evicts page 1
  endtask

  // Zero reads as one frame, anything above the built count as all frames.
  task automatic test_frame_count_limits();
    set_frames(4'd0);
    send_ref(8'd10, 1'b0);
    send_ref(8'd10, 1'b0);
    send_ref(8'd11, 1'b0);
    set_frames(4'd15);
    send_ref(8'd11, 1'b0);
    send_ref(8'd12, 1'b0);
  endtask

  // Shrink then grow the count: hidden frames keep their pages, and a page
  // held twice hits in the lower frame.
  task automatic test_count_change();
    set_frames(4'd8);
    send_ref(8'd30, 1'b1);
    send_ref(8'd31, 1'b0);
    send_ref(8'd32, 1'b0);
    set_frames(4'd1);
    send_ref(8'd32, 1'b0);    // evicts 30 from frame 0
    set_frames(4'd8);
    send_ref(8'd32, 1'b0);    // in frames 0 and 2
    send_ref(8'd31, 1'b0);
  endtask

  // first_ref clears frames and fault count ahead of its own reference.
  task automatic test_first_ref_clear();
    send_ref(8'd40, 1'b0);
    send_ref(8'd41, 1'b1);
    send_ref(8'd40, 1'b0);
  endtask

  // Hold the receiver off while the sender keeps offering, so input stalls.
  task automatic test_backpressure();
    settle();
    calm <= 1'b1;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    for (int i = 0; i < 40; i++) send_ref(8'($urandom_range(60, 69)), 1'b0);
    settle();
    calm <= 1'b0;
  endtask

  // Random phases over many frame counts; pages mostly from a sliding
  // working set a little larger than the frames, so hits and evictions mix.
  task automatic test_random_stream();
    logic [3:0] plan [14] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd2, 4'd9,
                              4'd7, 4'd3, 4'd12, 4'd5, 4'd6, 4'd8, 4'd1};
    int span;
    int base;
    logic [7:0] pg;
    for (int ph = 0; ph < 14; ph++) begin
      set_frames(plan[ph]);
      calm <= (ph == 4);
      span = (plan[ph] == 0) ? 1 : (plan[ph] > NUM_FRAMES ? NUM_FRAMES : plan[ph]);
      span = span + 3;
      base = $urandom_range(255);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(49) == 0) base = $urandom_range(255);
        if ($urandom_range(99) < 80) pg = 8'(base + $urandom_range(span - 1));
        else pg = 8'($urandom_range(255));
        send_ref(pg, $urandom_range(99) < 2);
      end
    end
    settle();
    calm <= 1'b0;
  endtask

  initial begin
    clear_frames();
    frames_cfg = 4'(NUM_FRAMES);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_default_fill();
    test_frame_count_limits();
    test_count_change();
    test_first_ref_clear();
    test_backpressure();
    test_random_stream();
    settle();
    if (mismatches == 0 && expected_outcomes.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
